// ===== src/horner_polynomial_eval_core_assert.svh =====
// assertion macros for the horner polynomial evaluator
// included by the top level, no other dependencies
`ifndef HORNER_POLYNOMIAL_EVAL_CORE_ASSERT_SVH
`define HORNER_POLYNOMIAL_EVAL_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// implication or plain property, checked at each rising edge outside reset
`define HPE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition that must never be seen
`define HPE_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define HPE_ASSERT(lbl, clk, rstn, prop, msg)
`define HPE_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== src/hpe_pkg.sv =====
// shared constants, types and helpers for the horner polynomial evaluator
// no dependencies
package hpe_pkg;

	localparam int COEF_REGS     = 8;
	localparam int NUM_COEFS_DEF = 8;
	localparam int IDX_W         = 3;
	localparam int APB_AW        = 6;
	localparam int EW            = 13;
	localparam int NMW           = 56;
	localparam int RND_LAT       = 2;
	localparam int MUL_LAT       = 4 + RND_LAT;
	localparam int ADD_LAT       = 5 + RND_LAT;
	localparam int STEP_LAT      = MUL_LAT + ADD_LAT;
	localparam logic [10:0] EXP_ONES  = 11'h7FF;
	localparam logic [12:0] EXP_MAX   = 13'd2047;
	localparam logic [63:0] CANON_NAN = 64'h7FF8000000000000;

	// unpacked binary64 operand
	typedef struct packed {
		logic        sign;
		logic        nan;
		logic        inf;
		logic        zero;
		logic [10:0] exp;
		logic [52:0] mant;
	} fp_unp_t;

	// operand for the rounding stages of both the multiplier and the adder
	typedef struct packed {
		logic                  sign;
		logic signed [EW-1:0]  exp;
		logic [NMW-1:0]        nm;
		logic                  spec;
		logic [63:0]           spec_val;
	} rnd_in_t;

	function automatic fp_unp_t fp_unpack(input logic [63:0] b);
		fp_unp_t u;
		u.sign = b[63];
		u.nan  = (b[62:52] == EXP_ONES) && (b[51:0] != 52'd0);
		u.inf  = (b[62:52] == EXP_ONES) && (b[51:0] == 52'd0);
		u.zero = (b[62:0] == 63'd0);
		u.exp  = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
		u.mant = {(b[62:52] != 11'd0), b[51:0]};
		return u;
	endfunction

	function automatic logic is_nan(input logic [63:0] b);
		return (b[62:52] == EXP_ONES) && (b[51:0] != 52'd0);
	endfunction

endpackage

// ===== src/hpe_fround.sv =====
// two-stage round-to-nearest-even and pack for binary64 results
// depends on hpe_pkg
module hpe_fround (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  hpe_pkg::rnd_in_t rin,
	output logic            out_valid,
	output logic [63:0]     z
);
	import hpe_pkg::*;

	logic           v_s1, v_s2;
	logic           sign_s1;
	logic [11:0]    exp_s1;
	logic [NMW-1:0] nm_s1;
	logic           spec_s1;
	logic [63:0]    sval_s1;
	logic [63:0]    z_s2;

	logic            denorm;
	logic [EW-1:0]   shamt_full;
	logic [5:0]      shamt;
	logic [NMW+63:0] wide;
	logic            lost;

	// subnormal alignment: shift right until the exponent reaches one
	always_comb begin
		denorm     = rin.exp < 13'sd1;
		shamt_full = EW'(13'sd1 - rin.exp);
		if (!denorm) begin
			shamt = 6'd0;
		end else if (shamt_full > EW'(63)) begin
			shamt = 6'd63;
		end else begin
			shamt = shamt_full[5:0];
		end
		wide = {rin.nm, 64'd0} >> shamt;
		lost = |wide[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1 <= rin.sign;
			exp_s1  <= denorm ? 12'd1 : rin.exp[11:0];
			nm_s1   <= {wide[NMW+63:65], wide[64] | lost};
			spec_s1 <= rin.spec;
			sval_s1 <= rin.spec_val;
		end
	end

	logic [52:0] m53;
	logic        up;
	logic [53:0] mr;
	logic [12:0] ef;
	logic [12:0] field;
	logic        ovf;
	logic [63:0] packed_val;

	// rounding increment, exponent adjust and overflow to infinity
	always_comb begin
		m53   = nm_s1[NMW-1:3];
		up    = nm_s1[2] & (nm_s1[1] | nm_s1[0] | m53[0]);
		mr    = {1'b0, m53} + 54'(up);
		ef    = {1'b0, exp_s1} + 13'(mr[53]);
		field = (mr[53] | mr[52]) ? ef : 13'd0;
		ovf   = (mr[53] | mr[52]) && (ef >= EXP_MAX);
		if (spec_s1) begin
			packed_val = sval_s1;
		end else if (ovf) begin
			packed_val = {sign_s1, EXP_ONES, 52'd0};
		end else begin
			packed_val = {sign_s1, field[10:0], mr[51:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s2 <= packed_val;
		end
	end

	assign out_valid = v_s2;
	assign z         = z_s2;

endmodule

// ===== src/hpe_fmul.sv =====
// pipelined binary64 multiplier: partial products, sum, normalize, round
// depends on hpe_pkg and hpe_fround
module hpe_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        out_valid,
	output logic [63:0] z
);
	import hpe_pkg::*;

	typedef struct packed {
		logic        sign;
		logic [11:0] esum;
		logic        spec;
		logic [63:0] sval;
	} mside_t;

	logic   v_s1, v_s2, v_s3, v_s4;
	mside_t sd_s1, sd_s2, sd_s3;
	logic [51:0] hh_s1;
	logic [52:0] hl_s1, lh_s1;
	logic [53:0] ll_s1;
	logic [105:0] prod_s2, prod_s3;
	logic [6:0]   lz_s3;
	rnd_in_t      rin_s4;

	fp_unp_t ua, ub;
	mside_t  sd_in;

	// operand unpack, special cases and four partial products
	always_comb begin
		ua = fp_unpack(a);
		ub = fp_unpack(b);
		sd_in.sign = ua.sign ^ ub.sign;
		sd_in.esum = 12'(ua.exp) + 12'(ub.exp);
		sd_in.spec = 1'b1;
		if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
			sd_in.sval = CANON_NAN;
		end else if (ua.inf || ub.inf) begin
			sd_in.sval = {sd_in.sign, EXP_ONES, 52'd0};
		end else if (ua.zero || ub.zero) begin
			sd_in.sval = {sd_in.sign, 63'd0};
		end else begin
			sd_in.spec = 1'b0;
			sd_in.sval = 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1 <= sd_in;
			hh_s1 <= ua.mant[52:27] * ub.mant[52:27];
			hl_s1 <= ua.mant[52:27] * ub.mant[26:0];
			lh_s1 <= ua.mant[26:0] * ub.mant[52:27];
			ll_s1 <= ua.mant[26:0] * ub.mant[26:0];
		end
	end

	// partial product sum
	logic [53:0] mid;
	assign mid = 54'(hl_s1) + 54'(lh_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2   <= sd_s1;
			prod_s2 <= {hh_s1, 54'd0} + (106'(mid) << 27) + 106'(ll_s1);
		end
	end

	// leading zero count of the product
	logic [6:0] lz;
	always_comb begin
		lz = 7'd0;
		for (int i = 0; i < 106; i++) begin
			if (prod_s2[i]) begin
				lz = 7'(105 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3   <= sd_s2;
			prod_s3 <= prod_s2;
			lz_s3   <= lz;
		end
	end

	// normalize and form the rounding operand
	logic [105:0] norm;
	rnd_in_t      rin_n;
	always_comb begin
		norm           = prod_s3 << lz_s3;
		rin_n.sign     = sd_s3.sign;
		rin_n.exp      = $signed(EW'({1'b0, sd_s3.esum}) - EW'(lz_s3) - EW'(1022));
		rin_n.nm       = {norm[105:51], |norm[50:0]};
		rin_n.spec     = sd_s3.spec;
		rin_n.spec_val = sd_s3.sval;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rin_s4 <= rin_n;
		end
	end

	hpe_fround u_rnd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.rin       (rin_s4),
		.out_valid (out_valid),
		.z         (z)
	);

endmodule

// ===== src/hpe_fadd.sv =====
// pipelined binary64 adder: swap, align, add, normalize, round
// depends on hpe_pkg and hpe_fround
module hpe_fadd (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        out_valid,
	output logic [63:0] z
);
	import hpe_pkg::*;

	typedef struct packed {
		logic        sign;
		logic [10:0] eb;
		logic        sub;
		logic        spec;
		logic [63:0] sval;
	} aside_t;

	logic   v_s1, v_s2, v_s3, v_s4, v_s5;
	aside_t sd_s1, sd_s2, sd_s3, sd_s4;
	logic [52:0] mb_s1, ms_s1;
	logic [10:0] d_s1;
	logic [55:0] big_s2, sm_s2;
	logic [56:0] sum_s3, sum_s4;
	logic [5:0]  lz_s4;
	rnd_in_t     rin_s5;

	fp_unp_t ua, ub, ubig, usml;
	logic    a_big;
	aside_t  sd_in;

	// magnitude swap and special cases
	always_comb begin
		ua    = fp_unpack(a);
		ub    = fp_unpack(b);
		a_big = a[62:0] >= b[62:0];
		ubig  = a_big ? ua : ub;
		usml  = a_big ? ub : ua;
		sd_in.sign = ubig.sign;
		sd_in.eb   = ubig.exp;
		sd_in.sub  = ua.sign ^ ub.sign;
		sd_in.spec = 1'b1;
		if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign))) begin
			sd_in.sval = CANON_NAN;
		end else if (ua.inf) begin
			sd_in.sval = {ua.sign, EXP_ONES, 52'd0};
		end else if (ub.inf) begin
			sd_in.sval = {ub.sign, EXP_ONES, 52'd0};
		end else if (ua.zero && ub.zero) begin
			sd_in.sval = {ua.sign & ub.sign, 63'd0};
		end else if (ua.zero) begin
			sd_in.sval = b;
		end else if (ub.zero) begin
			sd_in.sval = a;
		end else begin
			sd_in.spec = 1'b0;
			sd_in.sval = 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1 <= sd_in;
			mb_s1 <= ubig.mant;
			ms_s1 <= usml.mant;
			d_s1  <= ubig.exp - usml.exp;
		end
	end

	// align the smaller operand with a sticky bit
	logic [5:0]   dc;
	logic [119:0] wide;
	always_comb begin
		dc   = (d_s1 > 11'd63) ? 6'd63 : d_s1[5:0];
		wide = {ms_s1, 3'd0, 64'd0} >> dc;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2  <= sd_s1;
			big_s2 <= {mb_s1, 3'd0};
			sm_s2  <= {wide[119:65], wide[64] | (|wide[63:0])};
		end
	end

	// add or subtract magnitudes, exact cancellation gives +0
	logic [56:0] sum;
	aside_t      sd_a;
	always_comb begin
		sum  = sd_s2.sub ? ({1'b0, big_s2} - {1'b0, sm_s2}) : ({1'b0, big_s2} + {1'b0, sm_s2});
		sd_a = sd_s2;
		if (!sd_s2.spec && (sum == 57'd0)) begin
			sd_a.spec = 1'b1;
			sd_a.sval = 64'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3  <= sd_a;
			sum_s3 <= sum;
		end
	end

	// leading zero count of the sum
	logic [5:0] lz;
	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 57; i++) begin
			if (sum_s3[i]) begin
				lz = 6'(56 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s4  <= sd_s3;
			sum_s4 <= sum_s3;
			lz_s4  <= lz;
		end
	end

	// normalize and form the rounding operand
	logic [56:0] norm;
	rnd_in_t     rin_n;
	always_comb begin
		norm           = sum_s4 << lz_s4;
		rin_n.sign     = sd_s4.sign;
		rin_n.exp      = $signed(EW'(sd_s4.eb) + EW'(1) - EW'(lz_s4));
		rin_n.nm       = {norm[56:2], norm[1] | norm[0]};
		rin_n.spec     = sd_s4.spec;
		rin_n.spec_val = sd_s4.sval;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rin_s5 <= rin_n;
		end
	end

	hpe_fround u_rnd (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.rin       (rin_s5),
		.out_valid (out_valid),
		.z         (z)
	);

endmodule

// ===== src/hpe_step.sv =====
// one horner step: r*x rounded, then plus coefficient rounded
// depends on hpe_pkg, hpe_fmul and hpe_fadd
module hpe_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        active,
	input  logic [63:0] coef,
	input  logic        in_valid,
	input  logic [63:0] r_in,
	input  logic [63:0] x_in,
	input  logic        last_in,
	output logic        out_valid,
	output logic [63:0] r_out,
	output logic [63:0] x_out,
	output logic        last_out
);
	import hpe_pkg::*;

	typedef struct packed {
		logic        last;
		logic [63:0] x;
		logic [63:0] r;
	} sband_t;

	sband_t      side_s [STEP_LAT];
	logic        mul_v;
	logic [63:0] mul_z;
	logic [63:0] add_z;

	// sample, flag and incoming partial result ride alongside the arithmetic
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= '{last: last_in, x: x_in, r: r_in};
			for (int k = 1; k < STEP_LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	hpe_fmul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.a         (r_in),
		.b         (x_in),
		.out_valid (mul_v),
		.z         (mul_z)
	);

	hpe_fadd u_add (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mul_v),
		.a         (mul_z),
		.b         (coef),
		.out_valid (out_valid),
		.z         (add_z)
	);

	// steps at or above the leading coefficient hand the value on untouched
	assign r_out    = active ? add_z : side_s[STEP_LAT-1].r;
	assign x_out    = side_s[STEP_LAT-1].x;
	assign last_out = side_s[STEP_LAT-1].last;

endmodule

// ===== src/horner_polynomial_eval_core.sv =====
// top level of the binary64 horner polynomial evaluator
// depends on hpe_pkg, hpe_step and horner_polynomial_eval_core_assert.svh
//
//  port group | dir | role
//  -----------+-----+------------------------------------------------
//  s_*        | in  | sample stream, tdata = x_value, tlast = last_in
//  m_*        | out | result stream, tdata = poly_value, tlast = last_out
//  p*         | in  | apb register port, coef_k at byte address 8*k
//
// one sample per cycle while the output buffer is not full; each horner
// step is a multiply then an add, then the output register.
// reset clears valid bits, the output buffer and the coefficients (+0.0).
// the whole pipeline holds while the two-entry output buffer is full; it
// takes one more transfer after the first result stalls.
`include "horner_polynomial_eval_core_assert.svh"
module horner_polynomial_eval_core #(
	parameter int NUM_COEFS = hpe_pkg::NUM_COEFS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hpe_pkg::APB_AW-1:0] paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [63:0]                s_tdata,   // [63:0] x_value
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [63:0]                m_tdata,   // [63:0] poly_value
	output logic                       m_tlast
);
	import hpe_pkg::*;

	localparam int NSTEP = NUM_COEFS - 1;

	typedef struct packed {
		logic        last;
		logic [63:0] val;
	} res_t;

	logic [63:0]      coef_q [COEF_REGS];
	logic [IDX_W-1:0] top_idx;
	logic [63:0]      r0;
	logic             en;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < COEF_REGS; k++) begin
				coef_q[k] <= 64'd0;
			end
		end else if (psel && penable && pwrite) begin
			for (int k = 0; k < COEF_REGS; k++) begin
				if (paddr[APB_AW-1:3] == IDX_W'(k)) begin
					coef_q[k] <= pwdata;
				end
			end
		end
	end

	// register reads
	always_comb begin
		prdata = 64'd0;
		for (int k = 0; k < COEF_REGS; k++) begin
			if (paddr[APB_AW-1:3] == IDX_W'(k)) begin
				prdata = coef_q[k];
			end
		end
	end
	assign pready = 1'b1;

	// highest nonzero coefficient in use and its value
	always_comb begin
		top_idx = '0;
		r0      = coef_q[0];
		for (int k = 1; k < NUM_COEFS; k++) begin
			if (coef_q[k][62:0] != 63'd0) begin
				top_idx = IDX_W'(k);
				r0      = coef_q[k];
			end
		end
	end

	// horner chain
	logic        ch_v    [NSTEP+1];
	logic [63:0] ch_r    [NSTEP+1];
	logic [63:0] ch_x    [NSTEP+1];
	logic        ch_last [NSTEP+1];

	assign ch_v[0]    = s_tvalid & en;
	assign ch_r[0]    = r0;
	assign ch_x[0]    = s_tdata;
	assign ch_last[0] = s_tlast;

	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		localparam int CI = NUM_COEFS - 2 - j;
		hpe_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.active    (IDX_W'(CI) < top_idx),
			.coef      (coef_q[CI]),
			.in_valid  (ch_v[j]),
			.r_in      (ch_r[j]),
			.x_in      (ch_x[j]),
			.last_in   (ch_last[j]),
			.out_valid (ch_v[j+1]),
			.r_out     (ch_r[j+1]),
			.x_out     (ch_x[j+1]),
			.last_out  (ch_last[j+1])
		);
	end

	// any nan leaves as the canonical quiet nan
	res_t fin;
	assign fin.val  = is_nan(ch_r[NSTEP]) ? CANON_NAN : ch_r[NSTEP];
	assign fin.last = ch_last[NSTEP];

	// two-entry output buffer
	res_t       out0_q, out1_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign en       = (count_q != 2'd2);
	assign s_tready = en;
	assign push     = en & ch_v[NSTEP];
	assign pop      = (count_q != 2'd0) & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		priority if (pop && count_q == 2'd2) begin
			out0_q <= out1_q;
		end else if (push && (count_q == 2'd0 || pop)) begin
			out0_q <= fin;
		end else if (push) begin
			out1_q <= fin;
		end else begin
			out0_q <= out0_q;
		end
	end

	assign m_tvalid = (count_q != 2'd0);
	assign m_tdata  = out0_q.val;
	assign m_tlast  = out0_q.last;

	// checks
	`HPE_ASSERT_NEVER(a_count_range, clk, arst_n, count_q == 2'd3, "output buffer count out of range")
	`HPE_ASSERT(a_nan_canon, clk, arst_n, (m_tvalid && m_tdata[62:52] == EXP_ONES && m_tdata[51:0] != 52'd0) |-> (m_tdata == CANON_NAN), "non-canonical nan on output")
	`HPE_ASSERT(a_drain, clk, arst_n, (count_q == 2'd1 && pop && !push) |=> !m_tvalid, "output buffer did not drain")

endmodule

// ===== tb/horner_polynomial_eval_core_tb.sv =====
// testbench for horner_polynomial_eval_core: directed table, then random phases
// depends on hpe_pkg and the rtl of horner_polynomial_eval_core
module horner_polynomial_eval_core_tb;
	import hpe_pkg::*;

	localparam int NCOEF      = NUM_COEFS_DEF;
	localparam int DRAIN      = 13 * (NCOEF - 1) + 20;
	localparam int STALL_MAX  = 6000;
	localparam int RAND_ITEMS = 500;
	localparam logic [63:0] POS_ZERO = 64'h0000000000000000;
	localparam logic [63:0] NEG_ZERO = 64'h8000000000000000;
	localparam logic [63:0] ONE      = 64'h3FF0000000000000;
	localparam logic [63:0] TWO      = 64'h4000000000000000;
	localparam logic [63:0] THREE    = 64'h4008000000000000;
	localparam logic [63:0] POS_INF  = 64'h7FF0000000000000;
	localparam logic [63:0] NEG_INF  = 64'hFFF0000000000000;
	localparam logic [63:0] MAX_FIN  = 64'h7FEFFFFFFFFFFFFF;
	localparam logic [63:0] MIN_SUB  = 64'h0000000000000001;
	localparam logic [63:0] SNAN_NEG = 64'hFFF0000000000001;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [63:0] pwdata, prdata;
	logic pready;
	logic s_tvalid, s_tready, s_tlast;
	logic [63:0] s_tdata;        // [63:0] x_value
	logic m_tvalid, m_tready, m_tlast;
	logic [63:0] m_tdata;        // [63:0] poly_value

	horner_polynomial_eval_core DUT (.*);

	// result expected for each accepted sample, oldest first
	typedef struct {
		logic [63:0] poly;
		logic        last;
	} poly_result_t;

	// one directed row; exp_given marks a result typed in by hand
	typedef struct {
		int          setting;
		logic [63:0] x;
		logic        last;
		logic        exp_given;
		logic [63:0] poly;
	} dir_row_t;

	poly_result_t pending_q[$];
	logic [63:0]  coef_shadow [COEF_REGS];
	int           mismatches = 0;
	int           items_sent = 0;
	int           results_seen = 0;
	int           quiet_cycles = 0;
	int           stall_left = 0;
	bit           no_idle = 0;

	// clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// idle length: mostly none or short, sometimes long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random binary64 operand spread over normal, extreme and special values
	function automatic logic [63:0] rand_fp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return {1'($urandom), 11'(1013 + $urandom_range(0, 20)),
				52'({$urandom, $urandom})};
		if (r < 80)
			return {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: return POS_ZERO;
			1: return NEG_ZERO;
			2: return POS_INF;
			3: return NEG_INF;
			4: return {1'($urandom), MAX_FIN[62:0]};
			5: return {1'($urandom), 11'd0, 52'({$urandom, $urandom})};
			6: return {1'($urandom), 11'h7FF, 52'({$urandom, $urandom}) | 52'd1};
			default: return {1'($urandom), 11'(1000 + $urandom_range(0, 46)), 52'd0};
		endcase
	endfunction

	// p(x) by horner's rule, product and sum each rounded to binary64
	function automatic logic [63:0] horner_eval(input logic [63:0] xb);
		int   top;
		real  xr, acc, prod;
		logic [63:0] rb;
		top = NCOEF - 1;
		while (top > 0 && coef_shadow[top][62:0] == 63'd0)
			top--;
		rb = coef_shadow[top];
		if (top > 0) begin
			xr  = $bitstoreal(xb);
			acc = $bitstoreal(coef_shadow[top]);
			for (int i = top - 1; i >= 0; i--) begin
				prod = acc * xr;
				acc  = prod + $bitstoreal(coef_shadow[i]);
			end
			rb = $realtobits(acc);
		end
		if (rb[62:52] == EXP_ONES && rb[51:0] != 52'd0)
			rb = CANON_NAN;
		return rb;
	endfunction

	// apb write: setup cycle then access cycle
	task automatic coef_write(input int idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(8 * idx);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		coef_shadow[idx] = val;
	endtask

	task automatic load_coefs(input logic [63:0] c [COEF_REGS]);
		for (int k = 0; k < COEF_REGS; k++)
			coef_write(k, c[k]);
	endtask

	// hold off until every pending result is back, then let the pipe empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// one sample transfer; valid runs on into the next sample if no gap is drawn
	task automatic send_sample(input logic [63:0] x, input logic last,
			input logic exp_given, input logic [63:0] poly);
		int g;
		poly_result_t e;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= x;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		e.poly = exp_given ? poly : horner_eval(x);
		e.last = last;
		pending_q.push_back(e);
		items_sent++;
	endtask

	// result side: check each transfer, random backpressure, watchdog
	always @(posedge clk) begin
		poly_result_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected result %h last %b", $time, m_tdata, m_tlast);
					mismatches++;
				end else begin
					e = pending_q.pop_front();
					if (e.poly !== m_tdata) begin
						$display("%0t: poly_value expected %h actual %h", $time, e.poly,
							m_tdata);
						mismatches++;
					end
					if (e.last !== m_tlast) begin
						$display("%0t: last_out expected %b actual %b", $time, e.last,
							m_tlast);
						mismatches++;
					end
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_MAX) begin
				$display("tb: failure");
				$finish;
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else begin
				stall_left <= gap_len();
				m_tready   <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		logic [63:0] c [COEF_REGS];
		dir_row_t rows [$];
		int cur_setting;
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_tvalid = 0; s_tdata = '0; s_tlast = 0; m_tready = 0;
		foreach (coef_shadow[k]) coef_shadow[k] = POS_ZERO;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// setting 0: reset coefficients; 1: -0.0 constant only;
		// 2: 1 + 2x; 3: inf in the top register; 4: all max finite
		rows = '{
			'{0, POS_ZERO, 1'b0, 1'b1, POS_ZERO},
			'{0, POS_INF,  1'b1, 1'b1, POS_ZERO},
			'{0, SNAN_NEG, 1'b0, 1'b1, POS_ZERO},
			'{0, MAX_FIN,  1'b1, 1'b1, POS_ZERO},
			'{1, SNAN_NEG, 1'b0, 1'b1, NEG_ZERO},
			'{1, NEG_INF,  1'b1, 1'b1, NEG_ZERO},
			'{2, ONE,      1'b0, 1'b1, THREE},
			'{2, POS_ZERO, 1'b0, 1'b1, ONE},
			'{2, POS_INF,  1'b0, 1'b1, POS_INF},
			'{2, NEG_INF,  1'b1, 1'b1, NEG_INF},
			'{2, SNAN_NEG, 1'b0, 1'b1, CANON_NAN},
			'{2, MAX_FIN,  1'b0, 1'b0, '0},
			'{2, MIN_SUB,  1'b1, 1'b0, '0},
			'{2, 64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b1, CANON_NAN},
			'{3, POS_ZERO, 1'b0, 1'b1, CANON_NAN},
			'{3, ONE,      1'b0, 1'b1, POS_INF},
			'{3, NEG_INF,  1'b1, 1'b0, '0},
			'{3, TWO,      1'b0, 1'b0, '0},
			'{4, ONE,      1'b0, 1'b1, POS_INF},
			'{4, NEG_ZERO, 1'b0, 1'b0, '0},
			'{4, MIN_SUB,  1'b1, 1'b0, '0},
			'{4, 64'hBFF0000000000000, 1'b0, 1'b0, '0}
		};
		cur_setting = 0;
		foreach (rows[i]) begin
			if (rows[i].setting != cur_setting) begin
				drain();
				cur_setting = rows[i].setting;
				foreach (c[k]) c[k] = POS_ZERO;
				case (cur_setting)
					1: c[0] = NEG_ZERO;
					2: begin c[0] = ONE; c[1] = TWO; c[7] = NEG_ZERO; end
					3: begin c[0] = ONE; c[7] = POS_INF; end
					default: foreach (c[k]) c[k] = MAX_FIN;
				endcase
				load_coefs(c);
			end
			send_sample(rows[i].x, rows[i].last, rows[i].exp_given, rows[i].poly);
		end

		// random phases, each with its own coefficient set and degree
		for (int ph = 0; ph < 6; ph++) begin
			int deg;
			drain();
			deg = (ph == 0) ? NCOEF - 1 : $urandom_range(0, NCOEF - 1);
			foreach (c[k]) begin
				if (k > deg)
					c[k] = $urandom_range(0, 1) ? rand_fp() : {1'($urandom), 63'd0};
				else
					c[k] = rand_fp();
			end
			if (deg < NCOEF - 1)
				for (int k = deg + 1; k < NCOEF; k++)
					c[k] = {1'($urandom), 63'd0};
			load_coefs(c);
			no_idle = (ph == 2);
			for (int n = 0; n < RAND_ITEMS / 6; n++)
				send_sample(($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : rand_fp(),
					1'($urandom), 1'b0, '0);
		end
		no_idle = 0;
		s_tvalid <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		$display("covered %0d samples and %0d results over 5 directed and 6 random",
			items_sent, results_seen);
		$display("coefficient settings with stalls on both streams, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== horner_polynomial_eval_core.f =====
+incdir+src
src/hpe_pkg.sv
src/hpe_fround.sv
src/hpe_fmul.sv
src/hpe_fadd.sv
src/hpe_step.sv
src/horner_polynomial_eval_core.sv
tb/horner_polynomial_eval_core_tb.sv
